>>> rtl/cph_pkg.sv
//------------------------------------------------------------------------------
// cph_pkg
// Shared types and constants for the clock phase histogram.
//------------------------------------------------------------------------------
`default_nettype none

package cph_pkg;

    localparam int TS_W     = 48;
    localparam int CNT_W    = 32;
    localparam int CHAN_W   = 3;
    localparam int IDX_W    = 10;
    localparam int NUM_BINS_DEF      = 1024;
    localparam int PENDING_DEPTH_DEF = 16;
    localparam int ADDR_W   = 6;

    localparam logic [1:0] KIND_TAG   = 2'd0;
    localparam logic [1:0] KIND_SWEEP = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_IGNORED  = 2'd1;
    localparam logic [1:0] ST_DROPPED  = 2'd2;
    localparam logic [1:0] ST_RANGE    = 2'd3;

    localparam logic [2:0] REG_CLOCK_CH  = 3'd0;
    localparam logic [2:0] REG_DATA_CH   = 3'd1;
    localparam logic [2:0] REG_WIN_START = 3'd2;
    localparam logic [2:0] REG_WIN_END   = 3'd3;
    localparam logic [2:0] REG_NOMINAL   = 3'd4;
    localparam logic [2:0] REG_BIN_WIDTH = 3'd5;

    typedef struct packed {
        logic [1:0]        kind;
        logic [CHAN_W-1:0] tag_channel;
        logic [TS_W-1:0]   timestamp;
        logic [IDX_W-1:0]  bin_index;
    } in_item_t;

    typedef struct packed {
        logic [CNT_W-1:0] bin_count;
        logic [1:0]       status;
        logic [4:0]       tags_binned;
    } out_item_t;

    // divider handshake
    typedef struct packed {
        logic            start;
        logic [TS_W-1:0] delta;
        logic [TS_W-1:0] period;
        logic [CNT_W-1:0] nominal;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] quotient;
        logic             big;
    } div_rsp_t;

endpackage

`default_nettype wire

>>> rtl/cph_scale.sv
//------------------------------------------------------------------------------
// cph_scale
// Phase rescaler: multiply delta by nominal period in a low and a high half,
// then divide the 80-bit product by the period, one quotient bit per cycle.
//------------------------------------------------------------------------------
`default_nettype none

module cph_scale (
    input  wire              clk,
    input  wire              rst_n,
    input  cph_pkg::div_req_t req,
    output cph_pkg::div_rsp_t rsp
);
    import cph_pkg::*;

    localparam int PROD_W = TS_W + CNT_W;
    localparam logic [6:0] LAST_BIT = 7'(PROD_W - 1);

    typedef enum logic [1:0] { S_IDLE, S_MUL_LO, S_MUL_HI, S_DIV } state_t;

    state_t              state_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [TS_W-1:0]     period_reg;
    logic [TS_W-1:0]     delta_reg;
    logic [CNT_W-1:0]    nom_reg;
    logic [TS_W:0]       rem_reg;
    logic [PROD_W-1:0]   quot_reg;
    logic [6:0]          bit_reg;
    logic                done_reg;

    logic [TS_W:0]   rem_shift;
    logic            take;
    logic [TS_W-1:0] hi_prod;

    assign rem_shift = {rem_reg[TS_W-1:0], prod_reg[PROD_W-1]};
    assign take      = rem_shift >= {1'b0, period_reg};
    // upper 16 delta bits times the nominal period
    assign hi_prod   = {16'd0, delta_reg[TS_W-1:32]} * {16'd0, nom_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == S_DIV) && (bit_reg == 7'd0);
            case (state_reg)
                S_IDLE:
                begin
                    if (req.start)
                    begin
                        delta_reg  <= req.delta;
                        period_reg <= req.period;
                        nom_reg    <= req.nominal;
                        state_reg  <= S_MUL_LO;
                    end
                end
                S_MUL_LO:
                begin
                    prod_reg  <= PROD_W'({32'd0, delta_reg[31:0]} * {32'd0, nom_reg});
                    state_reg <= S_MUL_HI;
                end
                S_MUL_HI:
                begin
                    prod_reg  <= prod_reg + {hi_prod, 32'd0};
                    rem_reg   <= '0;
                    quot_reg  <= '0;
                    bit_reg   <= LAST_BIT;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    rem_reg  <= take ? rem_shift - {1'b0, period_reg} : rem_shift;
                    quot_reg <= {quot_reg[PROD_W-2:0], take};
                    prod_reg <= {prod_reg[PROD_W-2:0], 1'b0};
                    bit_reg  <= bit_reg - 7'd1;
                    if (bit_reg == 7'd0)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign rsp = '{done: done_reg, quotient: quot_reg[CNT_W-1:0],
                   big: |quot_reg[PROD_W-1:CNT_W]};

endmodule

`default_nettype wire

>>> rtl/cph_regs.sv
//------------------------------------------------------------------------------
// cph_regs
// Configuration register file behind the APB-style port.
//------------------------------------------------------------------------------
`default_nettype none

module cph_regs (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         psel,
    input  wire                         penable,
    input  wire                         pwrite,
    input  wire [cph_pkg::ADDR_W-1:0]   paddr,
    input  wire [63:0]                  pwdata,
    output logic [63:0]                 prdata,
    output logic [cph_pkg::CHAN_W-1:0]  clock_channel,
    output logic [cph_pkg::CHAN_W-1:0]  data_channel,
    output logic [cph_pkg::TS_W-1:0]    window_start,
    output logic [cph_pkg::TS_W-1:0]    window_end,
    output logic [cph_pkg::CNT_W-1:0]   nominal_period,
    output logic [cph_pkg::CNT_W-1:0]   bin_width
);
    import cph_pkg::*;

    logic [2:0] sel;
    logic       wr;
    assign sel = paddr[ADDR_W-1:3];
    assign wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_channel  <= '0;
            data_channel   <= 3'd1;
            window_start   <= '0;
            window_end     <= '1;
            nominal_period <= 32'd1000;
            bin_width      <= 32'd1;
        end
        else if (wr)
        begin
            case (sel)
                REG_CLOCK_CH:  clock_channel  <= pwdata[CHAN_W-1:0];
                REG_DATA_CH:   data_channel   <= pwdata[CHAN_W-1:0];
                REG_WIN_START: window_start   <= pwdata[TS_W-1:0];
                REG_WIN_END:   window_end     <= pwdata[TS_W-1:0];
                REG_NOMINAL:   nominal_period <= pwdata[CNT_W-1:0];
                REG_BIN_WIDTH: bin_width      <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (sel)
            REG_CLOCK_CH:  prdata = 64'(clock_channel);
            REG_DATA_CH:   prdata = 64'(data_channel);
            REG_WIN_START: prdata = 64'(window_start);
            REG_WIN_END:   prdata = 64'(window_end);
            REG_NOMINAL:   prdata = 64'(nominal_period);
            REG_BIN_WIDTH: prdata = 64'(bin_width);
            default:       prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/cph_bindiv.sv
//------------------------------------------------------------------------------
// cph_bindiv
// Bin index: phase divided by bin width, restoring, one bit per cycle.
//------------------------------------------------------------------------------
`default_nettype none

module cph_bindiv (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        start,
    input  wire [cph_pkg::CNT_W-1:0]   num,
    input  wire [cph_pkg::CNT_W-1:0]   den,
    output logic                       done,
    output logic [cph_pkg::CNT_W-1:0]  quot
);
    import cph_pkg::*;

    logic              busy_reg;
    logic [4:0]        cnt_reg;
    logic [CNT_W-1:0]  num_reg;
    logic [CNT_W-1:0]  den_reg;
    logic [CNT_W:0]    rem_reg;
    logic [CNT_W:0]    rem_shift;
    logic              take;

    assign rem_shift = {rem_reg[CNT_W-1:0], num_reg[CNT_W-1]};
    assign take      = rem_shift >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
        end
        else
        begin
            done <= !start && busy_reg && (cnt_reg == 5'd0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd31;
                num_reg  <= num;
                den_reg  <= (den == '0) ? CNT_W'(1) : den;
                rem_reg  <= '0;
                quot     <= '0;
            end
            else if (busy_reg)
            begin
                rem_reg <= take ? rem_shift - {1'b0, den_reg} : rem_shift;
                quot    <= {quot[CNT_W-2:0], take};
                num_reg <= {num_reg[CNT_W-2:0], 1'b0};
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                    busy_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/clock_phase_histogram.sv
//------------------------------------------------------------------------------
// clock_phase_histogram
// Phase-folded time-tag histogram with a pending FIFO and a count memory.
//------------------------------------------------------------------------------
// A clock tag works through its pending data tags in turn, each through the
//   rescale, bin divide and count update steps that it needs.
// Flow: one item in flight, the next one taken after its result transfer.
// Reset: a clear of all NUM_BINS count memory entries with the input stalled;
//   a clear item runs the same sweep (configuration is still accepted).
`default_nettype none

module clock_phase_histogram #(
    parameter int NUM_BINS      = cph_pkg::NUM_BINS_DEF,
    parameter int PENDING_DEPTH = cph_pkg::PENDING_DEPTH_DEF
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         in_valid,
    output logic                        in_stall,
    input  cph_pkg::in_item_t           in_data,
    output logic                        out_valid,
    input  wire                         out_stall,
    output cph_pkg::out_item_t          out_data,
    input  wire                         psel,
    input  wire                         penable,
    input  wire                         pwrite,
    input  wire [cph_pkg::ADDR_W-1:0]   paddr,
    input  wire [63:0]                  pwdata,
    output logic [63:0]                 prdata,
    output logic                        pready
);
    import cph_pkg::*;

    localparam int BIN_AW = $clog2(NUM_BINS);
    localparam int PEND_AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int PCNT_W = $clog2(PENDING_DEPTH + 1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_PEND_RD, S_SCALE, S_BIN, S_HIST_RD, S_HIST_WR,
        S_READ_WAIT, S_OUT
    } state_t;

    // result with only a status code set
    function automatic out_item_t with_status(input logic [1:0] st);
        out_item_t r;
        r        = '0;
        r.status = st;
        return r;
    endfunction

    logic [CHAN_W-1:0] clock_channel, data_channel;
    logic [TS_W-1:0]   window_start, window_end;
    logic [CNT_W-1:0]  nominal_period, bin_width;

    assign pready = 1'b1;

    cph_regs u_regs (
        .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
        .clock_channel, .data_channel, .window_start, .window_end,
        .nominal_period, .bin_width
    );

    // Memories
    logic [TS_W-1:0]  pend_mem [PENDING_DEPTH];
    logic [CNT_W-1:0] hist_mem [NUM_BINS];
    logic [TS_W-1:0]  pend_rd_reg;
    logic [CNT_W-1:0] hist_rd_reg;

    state_t             state_reg;
    logic [TS_W-1:0]    prev_reg;
    logic               seen_reg;
    logic [PCNT_W-1:0]  pcnt_reg;
    logic [PCNT_W-1:0]  k_reg;
    logic [TS_W-1:0]    period_reg;
    logic [CNT_W-1:0]   phase_reg;
    logic [BIN_AW-1:0]  bin_reg;
    logic [BIN_AW-1:0]  clr_reg;
    logic               out_valid_reg;
    out_item_t          out_reg;
    logic [TS_W-1:0]    clk_ts_reg;
    logic               scale_start_reg;

    div_req_t dreq;
    div_rsp_t drsp;
    logic     bd_start, bd_done;
    logic [CNT_W-1:0] bd_quot;

    cph_scale u_scale (.clk, .rst_n, .req(dreq), .rsp(drsp));
    cph_bindiv u_bindiv (
        .clk, .rst_n, .start(bd_start), .num(phase_reg), .den(bin_width),
        .done(bd_done), .quot(bd_quot)
    );

    logic accept;
    assign in_stall = (state_reg != S_IDLE) || out_valid_reg;
    assign accept   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    logic in_win, is_clk, is_dat;
    assign in_win = in_data.timestamp >= window_start && in_data.timestamp < window_end;
    assign is_clk = in_data.tag_channel == clock_channel;
    assign is_dat = in_data.tag_channel == data_channel;

    logic [TS_W-1:0] delta_w;
    assign delta_w = (pend_rd_reg > prev_reg) ? pend_rd_reg - prev_reg : '0;

    // Launch the rescaler for a tag inside a nonzero period; launch the bin
    // divide for a zero period with a nonzero nominal period, or a kept phase.
    logic scale_go, bin_go;
    assign scale_go = (state_reg == S_OUT) && (period_reg != '0) && (delta_w < period_reg);
    assign bin_go   = ((state_reg == S_OUT) && (period_reg == '0) && (nominal_period != '0))
                      || ((state_reg == S_SCALE) && drsp.done && !drsp.big
                          && (drsp.quotient < nominal_period));

    // memory write/read controls
    logic              pend_we;
    logic              hist_we;
    logic [BIN_AW-1:0] hist_wa;
    logic [CNT_W-1:0]  hist_wd;
    logic [BIN_AW-1:0] hist_ra;
    logic              do_write_reg;

    always_comb
    begin
        pend_we = accept && in_data.kind == KIND_TAG && in_win && !is_clk && is_dat
                  && seen_reg && pcnt_reg < PCNT_W'(PENDING_DEPTH);
        hist_we = 1'b0;
        hist_wa = bin_reg;
        hist_wd = (hist_rd_reg == '1) ? hist_rd_reg : hist_rd_reg + 1'b1;
        hist_ra = bd_quot[BIN_AW-1:0];
        if (state_reg == S_CLEAR)
        begin
            hist_we = 1'b1;
            hist_wa = clr_reg;
            hist_wd = '0;
        end
        else if (state_reg == S_HIST_WR)
            hist_we = do_write_reg;
        if (state_reg == S_IDLE)
            hist_ra = BIN_AW'(in_data.bin_index);
    end

    always_ff @(posedge clk)
    begin
        if (pend_we)
            pend_mem[pcnt_reg[PEND_AW-1:0]] <= in_data.timestamp;
        pend_rd_reg <= pend_mem[k_reg[PEND_AW-1:0]];
        if (hist_we)
            hist_mem[hist_wa] <= hist_wd;
        hist_rd_reg <= hist_mem[hist_ra];
    end

    assign dreq = '{start: scale_start_reg, delta: delta_w, period: period_reg,
                    nominal: nominal_period};

    // Control: one item in flight; the result waits in out_reg.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_reg         <= '0;
            prev_reg        <= '0;
            seen_reg        <= 1'b0;
            pcnt_reg        <= '0;
            k_reg           <= '0;
            out_valid_reg   <= 1'b0;
            scale_start_reg <= 1'b0;
            bd_start        <= 1'b0;
        end
        else
        begin
            scale_start_reg <= scale_go;
            bd_start        <= bin_go;
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == BIN_AW'(NUM_BINS - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        case (in_data.kind)
                            KIND_TAG:
                            begin
                                if (!in_win || (!is_clk && !is_dat))
                                begin
                                    out_reg       <= with_status(ST_IGNORED);
                                    out_valid_reg <= 1'b1;
                                end
                                else if (is_clk)
                                begin
                                    out_reg    <= '0;
                                    clk_ts_reg <= in_data.timestamp;
                                    period_reg <= (in_data.timestamp > prev_reg) ?
                                                  in_data.timestamp - prev_reg : '0;
                                    k_reg      <= '0;
                                    if (seen_reg && pcnt_reg != '0)
                                        state_reg <= S_PEND_RD;
                                    else
                                    begin
                                        prev_reg      <= in_data.timestamp;
                                        seen_reg      <= 1'b1;
                                        pcnt_reg      <= '0;
                                        out_valid_reg <= 1'b1;
                                    end
                                end
                                else if (!seen_reg)
                                begin
                                    out_reg       <= with_status(ST_IGNORED);
                                    out_valid_reg <= 1'b1;
                                end
                                else if (pcnt_reg >= PCNT_W'(PENDING_DEPTH))
                                begin
                                    out_reg       <= with_status(ST_DROPPED);
                                    out_valid_reg <= 1'b1;
                                end
                                else
                                begin
                                    out_reg       <= '0;
                                    pcnt_reg      <= pcnt_reg + 1'b1;
                                    out_valid_reg <= 1'b1;
                                end
                            end
                            KIND_SWEEP:
                            begin
                                out_reg       <= with_status((pcnt_reg != '0) ?
                                                             ST_DROPPED : ST_OK);
                                seen_reg      <= 1'b0;
                                pcnt_reg      <= '0;
                                out_valid_reg <= 1'b1;
                            end
                            KIND_READ:
                            begin
                                if (32'(in_data.bin_index) >= 32'(NUM_BINS))
                                begin
                                    out_reg       <= with_status(ST_RANGE);
                                    out_valid_reg <= 1'b1;
                                end
                                else
                                begin
                                    out_reg   <= '0;
                                    state_reg <= S_READ_WAIT;
                                end
                            end
                            default:
                            begin
                                out_reg       <= '0;
                                clr_reg       <= '0;
                                state_reg     <= S_CLEAR;
                                out_valid_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                S_READ_WAIT:
                begin
                    out_reg.bin_count <= hist_rd_reg;
                    out_valid_reg     <= 1'b1;
                    state_reg         <= S_IDLE;
                end
                S_PEND_RD:
                begin
                    // pending entry k is in pend_rd_reg after this cycle
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (period_reg == '0)
                    begin
                        phase_reg <= '0;
                        if (nominal_period != '0)
                            state_reg <= S_BIN;
                        else
                            state_reg <= S_HIST_WR;
                    end
                    else if (delta_w >= period_reg)
                        state_reg <= S_HIST_WR;
                    else
                        state_reg <= S_SCALE;
                end
                S_SCALE:
                begin
                    if (drsp.done)
                    begin
                        phase_reg <= drsp.quotient;
                        if (drsp.big || drsp.quotient >= nominal_period)
                            state_reg <= S_HIST_WR;
                        else
                            state_reg <= S_BIN;
                    end
                end
                S_BIN:
                begin
                    if (bd_done)
                    begin
                        if (bd_quot >= CNT_W'(NUM_BINS))
                        begin
                            out_reg.status <= ST_RANGE;
                            state_reg      <= S_HIST_WR;
                        end
                        else
                        begin
                            bin_reg   <= bd_quot[BIN_AW-1:0];
                            state_reg <= S_HIST_RD;
                        end
                    end
                end
                S_HIST_RD:
                begin
                    // hist_rd_reg holds the bin now; write in the next cycle
                    if (out_reg.tags_binned != 5'd31)
                        out_reg.tags_binned <= out_reg.tags_binned + 5'd1;
                    state_reg <= S_HIST_WR;
                end
                S_HIST_WR:
                begin
                    // a skipped tag also passes here; only a binned one writes
                    k_reg <= k_reg + 1'b1;
                    if (k_reg + 1'b1 >= pcnt_reg)
                    begin
                        prev_reg      <= clk_ts_reg;
                        seen_reg      <= 1'b1;
                        pcnt_reg      <= '0;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else
                        state_reg <= S_PEND_RD;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // hist write from S_HIST_WR only after a real bin read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            do_write_reg <= 1'b0;
        else
            do_write_reg <= (state_reg == S_HIST_RD);
    end

    // hist_ra in S_BIN done cycle is bd_quot: read lands in S_HIST_RD.

    property p_stall_busy;
        @(posedge clk) disable iff (!rst_n) (state_reg != S_IDLE) |-> in_stall;
    endproperty
    a_stall_busy: assert property (p_stall_busy) else $error("accepted while busy");

    property p_pcnt_bound;
        @(posedge clk) disable iff (!rst_n) pcnt_reg <= PCNT_W'(PENDING_DEPTH);
    endproperty
    a_pcnt_bound: assert property (p_pcnt_bound) else $error("pending overflow");

    property p_clear_no_out;
        @(posedge clk) disable iff (!rst_n)
            (state_reg == S_CLEAR && $past(state_reg) == S_CLEAR) |-> !accept;
    endproperty
    a_clear_no_out: assert property (p_clear_no_out) else $error("accept during clear");

endmodule

`default_nettype wire
